// ===== design/lfp_pkg.sv =====
// shared types and constants for the lidar frame parser
package lfp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h59;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_DL    = 4'd2,
        PH_DH    = 4'd3,
        PH_AL    = 4'd4,
        PH_AH    = 4'd5,
        PH_TL    = 4'd6,
        PH_TH    = 4'd7,
        PH_CHECK = 4'd8
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  sum;
        logic [15:0] distance;
        logic [15:0] amplitude;
        logic [15:0] temperature;
    } parse_state_t;

    typedef struct packed {
        logic [15:0] distance_cm;
        logic [15:0] amplitude;
        logic [15:0] temperature_raw;
        logic        checksum_ok;
    } frame_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:       PH_HUNT,
        sum:         8'd0,
        distance:    16'd0,
        amplitude:   16'd0,
        temperature: 16'd0
    };

endpackage

// ===== design/lfp_channels.sv =====
// valid/ready channels for received bytes and parsed frames
interface lfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfp_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance_cm;
    logic [15:0] amplitude;
    logic [15:0] temperature_raw;
    logic        checksum_ok;

    modport source (output valid, output distance_cm, output amplitude,
                    output temperature_raw, output checksum_ok, input ready);
    modport sink   (input valid, input distance_cm, input amplitude,
                    input temperature_raw, input checksum_ok, output ready);
endinterface

// ===== design/lfp_parse_core.sv =====
// one parser step: next state and optional frame for a received byte
module lfp_parse_core (
    input  lfp_pkg::parse_state_t cur,
    input  logic [7:0]            rx_byte,
    output lfp_pkg::parse_state_t nxt,
    output logic                  emit,
    output lfp_pkg::frame_t       frame
);
    import lfp_pkg::*;

    logic       is_sync;
    logic [7:0] sum_add;

    assign is_sync = (rx_byte == SYNC_BYTE);
    assign sum_add = cur.sum + rx_byte;

    assign frame.distance_cm     = cur.distance;
    assign frame.amplitude       = cur.amplitude;
    assign frame.temperature_raw = cur.temperature;
    assign frame.checksum_ok     = (cur.sum == rx_byte);

    always_comb
    begin
        nxt  = cur;
        emit = 1'b0;
        case (cur.phase)
            PH_SYNC2:
            begin
                if (is_sync)
                begin
                    nxt.sum   = sum_add;
                    nxt.phase = PH_DL;
                end
                else
                begin
                    nxt.phase = PH_HUNT;
                end
            end
            PH_CHECK:
            begin
                nxt.phase = PH_HUNT;
                emit      = 1'b1;
            end
            PH_DL, PH_DH, PH_AL, PH_AH, PH_TL, PH_TH:
            begin
                // a header byte inside the payload aborts the frame
                if (is_sync)
                begin
                    nxt.phase = PH_HUNT;
                end
                else
                begin
                    nxt.sum = sum_add;
                    case (cur.phase)
                        PH_DL:
                        begin
                            nxt.distance[7:0] = rx_byte;
                            nxt.phase         = PH_DH;
                        end
                        PH_DH:
                        begin
                            nxt.distance[15:8] = rx_byte;
                            nxt.phase          = PH_AL;
                        end
                        PH_AL:
                        begin
                            nxt.amplitude[7:0] = rx_byte;
                            nxt.phase          = PH_AH;
                        end
                        PH_AH:
                        begin
                            nxt.amplitude[15:8] = rx_byte;
                            nxt.phase           = PH_TL;
                        end
                        PH_TL:
                        begin
                            nxt.temperature[7:0] = rx_byte;
                            nxt.phase            = PH_TH;
                        end
                        default:
                        begin
                            nxt.temperature[15:8] = rx_byte;
                            nxt.phase             = PH_CHECK;
                        end
                    endcase
                end
            end
            default:
            begin
                // hunting, and any unused phase code
                if (is_sync)
                begin
                    nxt.sum   = rx_byte;
                    nxt.phase = PH_SYNC2;
                end
                else
                begin
                    nxt.phase = PH_HUNT;
                end
            end
        endcase
    end

endmodule

// ===== design/lidar_frame_parser.sv =====
// lidar frame parser top level: byte register, parse step, frame register
// output: the checksum byte is held in the byte register, and its frame then in the output register
// throughput: one byte word per cycle; the output register and the byte
// register decouple the sides, so a waiting frame stalls only the next frame
// reset: asynchronous, active low; parser hunts for the first header byte
module lidar_frame_parser (
    input  logic      clk,
    input  logic      rst_n,
    lfp_byte_if.sink  rx,
    lfp_frame_if.source frame
);
    import lfp_pkg::*;

    logic         byte_valid_reg;
    logic [7:0]   byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    frame_t       out_reg;
    logic         emit;
    frame_t       step_frame;
    logic         out_free;
    logic         step_go;

    lfp_parse_core u_core (
        .cur     (state_reg),
        .rx_byte (byte_reg),
        .nxt     (state_next),
        .emit    (emit),
        .frame   (step_frame)
    );

    assign out_free = !out_valid_reg || frame.ready;
    // the held word moves on unless it makes a frame with nowhere to go
    assign step_go  = byte_valid_reg && (!emit || out_free);
    assign rx.ready = !byte_valid_reg || step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            state_reg      <= PARSE_STATE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                byte_valid_reg <= rx.valid;
            end
            if (step_go)
            begin
                state_reg <= state_next;
            end
            if (step_go && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            byte_reg <= rx.rx_byte;
        end
        if (step_go && emit)
        begin
            out_reg <= step_frame;
        end
    end

    assign frame.valid           = out_valid_reg;
    assign frame.distance_cm     = out_reg.distance_cm;
    assign frame.amplitude       = out_reg.amplitude;
    assign frame.temperature_raw = out_reg.temperature_raw;
    assign frame.checksum_ok     = out_reg.checksum_ok;

endmodule
